[rtl/dpwp_pkg.sv]
// Shared types and constants for the depth pixel to world point block.
package dpwp_pkg;

	localparam int COORD_WIDTH_DEF = 12;
	localparam int FIELD_W = 12;
	localparam int DEPTH_W = 16;
	localparam int IDX_W = 4;
	localparam int COEF_W = 32;
	localparam int POINT_W = 32;
	localparam int INTR_W = 28;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 28;
	localparam int Z_W = 23;
	localparam int COEF_NUM = 12;
	localparam int TRANS_BASE = 9;

	localparam logic [COEF_W-1:0] ONE_Q28 = 32'h1000_0000;

	localparam logic [INTR_W-1:0] FOCAL_X_RST = 28'd33554432;
	localparam logic [INTR_W-1:0] FOCAL_Y_RST = 28'd33554432;
	localparam logic [INTR_W-1:0] CENTER_X_RST = 28'd20971520;
	localparam logic [INTR_W-1:0] CENTER_Y_RST = 28'd15728640;
	localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = 16'd100;
	localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 16'd20000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FOCAL_X,
		CFG_FOCAL_Y,
		CFG_CENTER_X,
		CFG_CENTER_Y,
		CFG_MIN_DEPTH,
		CFG_MAX_DEPTH
	} cfg_idx_t;

	typedef enum logic {
		ACT_PIXEL,
		ACT_LOAD
	} action_t;

	typedef struct packed {
		action_t                    action;
		logic [FIELD_W-1:0]         column;
		logic [FIELD_W-1:0]         row;
		logic [DEPTH_W-1:0]         depth_mm;
		logic [IDX_W-1:0]           coeff_index;
		logic signed [COEF_W-1:0]   coeff_value;
	} in_word_t;

	typedef struct packed {
		logic signed [POINT_W-1:0] point_x;
		logic signed [POINT_W-1:0] point_y;
		logic signed [POINT_W-1:0] point_z;
	} out_word_t;

endpackage

[rtl/dpwp_if.sv]
// Valid/ready channel interfaces for pixel input and point output words.
interface dpwp_in_if;
	logic                 valid;
	logic                 ready;
	dpwp_pkg::in_word_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dpwp_out_if;
	logic                 valid;
	logic                 ready;
	dpwp_pkg::out_word_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/dpwp_div.sv]
// Pipelined restoring divider with quotient overflow flag and sideband.
module dpwp_div #(
	parameter int NUM_W = 52,
	parameter int DIV_W = 28,
	parameter int QUO_W = 32,
	parameter int STEP_BITS = 2,
	parameter int SIDE_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [NUM_W-1:0]   num,
	input  logic [DIV_W-1:0]   div,
	input  logic [SIDE_W-1:0]  side_in,
	output logic [QUO_W-1:0]   quo,
	output logic               sat,
	output logic [SIDE_W-1:0]  side_out
);
	localparam int STAGES = QUO_W / STEP_BITS;
	localparam int HI_W = NUM_W - QUO_W;
	localparam int CMP_W = (HI_W > DIV_W) ? HI_W : DIV_W;

	logic [DIV_W-1:0]  rem_q  [STAGES+1];
	logic [QUO_W-1:0]  word_q [STAGES+1];
	logic              sat_q  [STAGES+1];
	logic [SIDE_W-1:0] side_q [STAGES+1];

	logic [HI_W-1:0] hi;
	assign hi = num[NUM_W-1:QUO_W];

	// entry: overflow when the quotient would need more than QUO_W bits
	always_ff @(posedge clk) begin
		if (en) begin
			sat_q[0]  <= CMP_W'(hi) >= CMP_W'(div);
			rem_q[0]  <= DIV_W'(hi);
			word_q[0] <= num[QUO_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q[0] <= '0;
		end else if (en) begin
			side_q[0] <= side_in;
		end
	end

	for (genvar s = 0; s < STAGES; s++) begin : g_stage
		logic [DIV_W-1:0] rem_n;
		logic [QUO_W-1:0] word_n;

		// numerator bits leave at the top of word, quotient bits enter at the bottom
		always_comb begin
			logic [DIV_W:0] t;
			logic ge;
			rem_n  = rem_q[s];
			word_n = word_q[s];
			for (int j = 0; j < STEP_BITS; j++) begin
				t  = {rem_n, word_n[QUO_W-1]};
				ge = t >= {1'b0, div};
				rem_n  = ge ? DIV_W'(t - {1'b0, div}) : DIV_W'(t);
				word_n = {word_n[QUO_W-2:0], ge};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[s+1]  <= rem_n;
				word_q[s+1] <= word_n;
				sat_q[s+1]  <= sat_q[s];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_q[s+1] <= '0;
			end else if (en) begin
				side_q[s+1] <= side_q[s];
			end
		end
	end

	assign quo      = word_q[STAGES];
	assign sat      = sat_q[STAGES];
	assign side_out = side_q[STAGES];

endmodule

[rtl/depth_pixel_to_world_point.sv]
// Depth pixel to world point: window test, pinhole back-projection, rigid transform.
// Throughput: one word per cycle; the whole pipeline advances together and stalls
// only while the output register holds a word not yet taken.
// Reset: intrinsics and depth window take their default values, the transform
// returns to identity rotation and zero translation, the pipeline empties.
module depth_pixel_to_world_point #(
	parameter int COORD_WIDTH = dpwp_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	dpwp_in_if.sink                         pixel,
	dpwp_out_if.source                      point,
	input  logic                            cfg_wr_en,
	input  logic [dpwp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dpwp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dpwp_pkg::*;

	// derived widths
	localparam int PIX_W    = COORD_WIDTH + 16;                       // pixel in Q.16
	localparam int OFFS_W   = ((PIX_W > INTR_W) ? PIX_W : INTR_W) + 1;  // signed offset
	localparam int ABS_W    = OFFS_W - 1;
	localparam int MAG_W    = ABS_W + Z_W;
	localparam int NUM_W    = MAG_W + 1;
	localparam int M_W      = 29;                                     // d*8192+62
	localparam int RCP_W    = 31;
	localparam int PROD_W   = M_W + RCP_W;
	localparam int RCP_SH   = 37;
	localparam int DIV_STEP = 2;

	// floor(2^37/125): estimate of m/125 is exact or one low
	localparam logic [RCP_W-1:0] RCP_125 = 31'd1099511627;
	localparam logic [M_W-1:0]   DIV_125 = 29'd125;
	localparam logic [M_W-1:0]   Z_BIAS  = 29'd62;   // 500/8, low bits of 65536*d are zero

	localparam logic signed [65:0] ROUND_Q28 = 66'sd134217728;
	localparam logic signed [38:0] MAX39 = 39'sd2147483647;
	localparam logic signed [38:0] MIN39 = -39'sd2147483648;
	localparam logic signed [POINT_W-1:0] MAX32 = 32'sh7FFF_FFFF;
	localparam logic signed [POINT_W-1:0] MIN32 = 32'sh8000_0000;

	typedef struct packed {
		logic                    valid;
		action_t                 act;
		logic [IDX_W-1:0]        idx;
		logic [COEF_W-1:0]       value;
		logic                    emit;      // pixel inside the depth window
	} ctl_t;

	typedef struct packed {
		ctl_t                    ctl;
		logic [Z_W-1:0]          z;
		logic                    neg_x;
	} side_t;

	// configuration registers
	logic [INTR_W-1:0]  focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [DEPTH_W-1:0] min_depth_q, max_depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q   <= FOCAL_X_RST;
			focal_y_q   <= FOCAL_Y_RST;
			center_x_q  <= CENTER_X_RST;
			center_y_q  <= CENTER_Y_RST;
			min_depth_q <= MIN_DEPTH_RST;
			max_depth_q <= MAX_DEPTH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FOCAL_X:   focal_x_q   <= cfg_data;
				CFG_FOCAL_Y:   focal_y_q   <= cfg_data;
				CFG_CENTER_X:  center_x_q  <= cfg_data;
				CFG_CENTER_Y:  center_y_q  <= cfg_data;
				CFG_MIN_DEPTH: min_depth_q <= cfg_data[DEPTH_W-1:0];
				CFG_MAX_DEPTH: max_depth_q <= cfg_data[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	// zero focal length acts as one lsb
	logic [INTR_W-1:0] div_x, div_y;
	assign div_x = (focal_x_q == '0) ? INTR_W'(1) : focal_x_q;
	assign div_y = (focal_y_q == '0) ? INTR_W'(1) : focal_y_q;

	// single advance for every stage; only the output register can hold it back
	logic adv;
	assign adv = !point.valid || point.ready;
	assign pixel.ready = adv;

	// s1: capture word, depth window, z numerator
	ctl_t                   ctl_s1;
	logic [COORD_WIDTH-1:0] col_s1, row_s1;
	logic [M_W-1:0]         m_s1;
	ctl_t                   ctl_in;
	logic                   keep_in;

	always_comb begin
		keep_in = (pixel.data.depth_mm != '0) &&
		          (pixel.data.depth_mm >= min_depth_q) &&
		          (pixel.data.depth_mm <= max_depth_q);
		ctl_in.valid = pixel.valid;
		ctl_in.act   = pixel.data.action;
		ctl_in.idx   = pixel.data.coeff_index;
		ctl_in.value = pixel.data.coeff_value;
		ctl_in.emit  = keep_in && (pixel.data.action == ACT_PIXEL);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1 <= COORD_WIDTH'(pixel.data.column);
			row_s1 <= COORD_WIDTH'(pixel.data.row);
			m_s1   <= {pixel.data.depth_mm, 13'd0} + Z_BIAS;
		end
	end

	// s2: reciprocal multiply for /125, pixel offsets from the principal point
	ctl_t              ctl_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [M_W-1:0]    m_s2;
	logic [OFFS_W-1:0] offx_s2, offy_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= PROD_W'(m_s1) * PROD_W'(RCP_125);
			m_s2    <= m_s1;
			offx_s2 <= OFFS_W'({col_s1, 16'd0}) - OFFS_W'(center_x_q);
			offy_s2 <= OFFS_W'({row_s1, 16'd0}) - OFFS_W'(center_y_q);
		end
	end

	// s3: correct z estimate, split offsets into sign and magnitude
	ctl_t             ctl_s3;
	logic [Z_W-1:0]   z_s3;
	logic [ABS_W-1:0] absx_s3, absy_s3;
	logic             negx_s3, negy_s3;
	logic [Z_W-1:0]   z_est;
	logic [M_W-1:0]   z_rem;

	always_comb begin
		z_est = prod_s2[RCP_SH +: Z_W];
		z_rem = m_s2 - M_W'(M_W'(z_est) * DIV_125);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s3    <= (z_rem >= DIV_125) ? z_est + Z_W'(1) : z_est;
			negx_s3 <= offx_s2[OFFS_W-1];
			negy_s3 <= offy_s2[OFFS_W-1];
			absx_s3 <= ABS_W'(offx_s2[OFFS_W-1] ? (~offx_s2 + OFFS_W'(1)) : offx_s2);
			absy_s3 <= ABS_W'(offy_s2[OFFS_W-1] ? (~offy_s2 + OFFS_W'(1)) : offy_s2);
		end
	end

	// s4: |offset| * z
	ctl_t             ctl_s4;
	logic [Z_W-1:0]   z_s4;
	logic [MAG_W-1:0] magx_s4, magy_s4;
	logic             negx_s4, negy_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s4    <= z_s3;
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			magx_s4 <= MAG_W'(absx_s3) * MAG_W'(z_s3);
			magy_s4 <= MAG_W'(absy_s3) * MAG_W'(z_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// divide by focal length with half-divisor bias (round half away from zero)
	logic [NUM_W-1:0]   numx, numy;
	side_t              side_in, side_out;
	logic [POINT_W-1:0] quo_x, quo_y;
	logic               sat_x, sat_y;
	logic               negy_out;

	assign numx = NUM_W'(magx_s4) + NUM_W'(div_x >> 1);
	assign numy = NUM_W'(magy_s4) + NUM_W'(div_y >> 1);

	always_comb begin
		side_in.ctl   = ctl_s4;
		side_in.z     = z_s4;
		side_in.neg_x = negx_s4;
	end

	dpwp_div #(
		.NUM_W(NUM_W), .DIV_W(INTR_W), .QUO_W(POINT_W),
		.STEP_BITS(DIV_STEP), .SIDE_W($bits(side_t))
	) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.num(numx), .div(div_x), .side_in(side_in),
		.quo(quo_x), .sat(sat_x), .side_out(side_out)
	);

	dpwp_div #(
		.NUM_W(NUM_W), .DIV_W(INTR_W), .QUO_W(POINT_W),
		.STEP_BITS(DIV_STEP), .SIDE_W(1)
	) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.num(numy), .div(div_y), .side_in(negy_s4),
		.quo(quo_y), .sat(sat_y), .side_out(negy_out)
	);

	// s6: apply sign and saturate camera-frame x and y
	ctl_t                      ctl_s6;
	logic signed [POINT_W-1:0] camx_s6, camy_s6, camz_s6;
	logic                      ovf_x, ovf_y;

	assign ovf_x = sat_x || quo_x[POINT_W-1];
	assign ovf_y = sat_y || quo_y[POINT_W-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_out.neg_x) begin
				camx_s6 <= ovf_x ? MIN32 : -$signed(quo_x);
			end else begin
				camx_s6 <= ovf_x ? MAX32 : $signed(quo_x);
			end
			if (negy_out) begin
				camy_s6 <= ovf_y ? MIN32 : -$signed(quo_y);
			end else begin
				camy_s6 <= ovf_y ? MAX32 : $signed(quo_y);
			end
			camz_s6 <= $signed(POINT_W'(side_out.z));
		end
	end

	// transform store; loads take effect in stream order at the s7 boundary
	logic signed [COEF_W-1:0] coef_q [COEF_NUM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_NUM; i++) begin
				coef_q[i] <= ((i % 4) == 0 && i < TRANS_BASE) ? ONE_Q28 : '0;
			end
		end else if (adv && ctl_s6.valid && ctl_s6.act == ACT_LOAD &&
		             ctl_s6.idx < IDX_W'(COEF_NUM)) begin
			coef_q[ctl_s6.idx] <= ctl_s6.value;
		end
	end

	// s7: nine Q.44 products, translation captured with the pixel
	ctl_t                     ctl_s7;
	logic signed [63:0]       p_s7 [9];
	logic signed [COEF_W-1:0] t_s7 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				p_s7[3*r]   <= 64'(coef_q[3*r])   * 64'(camx_s6);
				p_s7[3*r+1] <= 64'(coef_q[3*r+1]) * 64'(camy_s6);
				p_s7[3*r+2] <= 64'(coef_q[3*r+2]) * 64'(camz_s6);
				t_s7[r]     <= coef_q[TRANS_BASE + r];
			end
		end
	end

	// s8: row sums rounded half up to Q.16
	ctl_t                     ctl_s8;
	logic signed [37:0]       sum_s8 [3];
	logic signed [COEF_W-1:0] t_s8 [3];

	always_ff @(posedge clk) begin
		logic signed [65:0] acc;
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				acc = 66'(p_s7[3*r]) + 66'(p_s7[3*r+1]) + 66'(p_s7[3*r+2]) + ROUND_Q28;
				sum_s8[r] <= acc[65:28];
				t_s8[r]   <= t_s7[r];
			end
		end
	end

	// s9: add translation, saturate, output register
	logic                      out_v_q;
	logic signed [POINT_W-1:0] pt_q [3];

	always_ff @(posedge clk) begin
		logic signed [38:0] w;
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				w = 39'(sum_s8[r]) + 39'(t_s8[r]);
				if (w > MAX39) begin
					pt_q[r] <= MAX32;
				end else if (w < MIN39) begin
					pt_q[r] <= MIN32;
				end else begin
					pt_q[r] <= w[POINT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6  <= '0;
			ctl_s7  <= '0;
			ctl_s8  <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			ctl_s6  <= side_out.ctl;
			ctl_s7  <= ctl_s6;
			ctl_s8  <= ctl_s7;
			out_v_q <= ctl_s8.valid && ctl_s8.emit;
		end
	end

	assign point.valid        = out_v_q;
	assign point.data.point_x = pt_q[0];
	assign point.data.point_y = pt_q[1];
	assign point.data.point_z = pt_q[2];

endmodule
